// ===== hw/rtl/jci_pkg.sv =====
package jci_pkg;

  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned START_W  = 16;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned CNT16_W  = 16;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IX_W = 3;

  localparam int unsigned POS_W = SIZE_W + FRAC_BITS;
  localparam int unsigned DIV_N = RATE_W + FRAC_BITS;
  localparam int unsigned DEN_W = CNT16_W + 1;
  localparam int unsigned CNT_W = $clog2(DIV_N + 1);
  localparam int unsigned SUM_W = DIV_N + 2;

  localparam logic signed [RATE_W-1:0] DEAD_LOW  = -16'sd2000;
  localparam logic signed [RATE_W-1:0] DEAD_HIGH = 16'sd2000;
  localparam logic [MS_W-1:0]          LATCH_MS  = 32'd1000;

  localparam logic [CFG_IX_W-1:0] REG_WIDTH   = 3'd0;
  localparam logic [CFG_IX_W-1:0] REG_HEIGHT  = 3'd1;
  localparam logic [CFG_IX_W-1:0] REG_DIVIDER = 3'd2;
  localparam logic [CFG_IX_W-1:0] REG_START_X = 3'd3;
  localparam logic [CFG_IX_W-1:0] REG_START_Y = 3'd4;

  localparam int unsigned PC_W = 4;
  localparam logic [PC_W-1:0] PC_WAIT_IN = 4'd0;
  localparam logic [PC_W-1:0] PC_RATE    = 4'd1;
  localparam logic [PC_W-1:0] PC_RATE_WR = 4'd3;
  localparam logic [PC_W-1:0] PC_LAST    = 4'd11;

  typedef enum logic [2:0] {
    OP_WAIT_IN  = 3'd0,
    OP_DIV_RATE = 3'd1,
    OP_DIV_WAIT = 3'd2,
    OP_RATE_WR  = 3'd3,
    OP_DIV_STEP = 3'd4,
    OP_POS_UPD  = 3'd5,
    OP_FRAME    = 3'd6,
    OP_OUT      = 3'd7
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            axis;
    logic [PC_W-1:0] jmp;
  } ucode_t;

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] numer;
    logic [DEN_W-1:0] denom;
    logic [CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_N-1:0] quot;
  } div_rsp_t;

  function automatic ucode_t prog_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_WAIT_IN, axis: 1'b0, jmp: PC_WAIT_IN};
    case (pc)
      4'd0:  w = '{op: OP_WAIT_IN,  axis: 1'b0, jmp: PC_WAIT_IN};
      4'd1:  w = '{op: OP_DIV_RATE, axis: 1'b0, jmp: PC_RATE_WR};
      4'd2:  w = '{op: OP_DIV_WAIT, axis: 1'b0, jmp: PC_WAIT_IN};
      4'd3:  w = '{op: OP_RATE_WR,  axis: 1'b0, jmp: PC_WAIT_IN};
      4'd4:  w = '{op: OP_DIV_STEP, axis: 1'b0, jmp: PC_WAIT_IN};
      4'd5:  w = '{op: OP_DIV_WAIT, axis: 1'b0, jmp: PC_WAIT_IN};
      4'd6:  w = '{op: OP_POS_UPD,  axis: 1'b0, jmp: PC_WAIT_IN};
      4'd7:  w = '{op: OP_DIV_STEP, axis: 1'b1, jmp: PC_WAIT_IN};
      4'd8:  w = '{op: OP_DIV_WAIT, axis: 1'b1, jmp: PC_WAIT_IN};
      4'd9:  w = '{op: OP_POS_UPD,  axis: 1'b1, jmp: PC_WAIT_IN};
      4'd10: w = '{op: OP_FRAME,    axis: 1'b0, jmp: PC_WAIT_IN};
      4'd11: w = '{op: OP_OUT,      axis: 1'b0, jmp: PC_WAIT_IN};
      default: w = '{op: OP_WAIT_IN, axis: 1'b0, jmp: PC_WAIT_IN};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/joystick_cursor_integrator.sv =====
// Two-axis joystick cursor integrator. Each input word is one event; it may set one axis's
// rate from a joystick sample, then moves both cursor coordinates by rate / (fps + 1) and
// returns one output word with the integer cursor position. A small microcode program steps
// a plain datapath and one shared restoring divider that retires one quotient bit per cycle.
// An event runs to completion before the next word is accepted: the divider first forms the
// rate when a rate division is needed, then the step quotient for each axis. The next word
// can be taken in the cycle after the result is loaded, even while that result still waits
// in the output register. Configuration writes are always accepted; start writes load the
// cursor at once, size writes take effect at the next cursor update.
module joystick_cursor_integrator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [47:0] s_tdata_i,   // axis_sample [15:0], now_ms [47:16]
  input  logic [1:0]  s_tuser_i,   // action [0], axis_select [1]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // pointer_x [11:0], pointer_y [23:12]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned F  = jci_pkg::FRAC_BITS;
  localparam int unsigned PW = jci_pkg::POS_W;
  localparam int unsigned SW = jci_pkg::SUM_W;

  jci_pkg::ucode_t   ucode;
  jci_pkg::div_req_t div_req;
  jci_pkg::div_rsp_t div_rsp;

  logic [jci_pkg::PC_W-1:0] pc_q, pc_d;

  logic [jci_pkg::SIZE_W-1:0]  width_q, width_d, height_q, height_d;
  logic [jci_pkg::CNT16_W-1:0] divider_q, divider_d;
  logic [jci_pkg::START_W-1:0] start_x_q, start_x_d, start_y_q, start_y_d;

  logic signed [jci_pkg::RATE_W-1:0] rate_q [2];
  logic signed [jci_pkg::RATE_W-1:0] rate_d [2];
  logic [PW-1:0] pos_q [2];
  logic [PW-1:0] pos_d [2];

  logic [jci_pkg::CNT16_W-1:0] fcnt_q, fcnt_d, fps_q, fps_d;
  logic [jci_pkg::MS_W-1:0]    last_q, last_d;

  logic                              motion_q, motion_d, axis_q, axis_d;
  logic signed [jci_pkg::RATE_W-1:0] sample_q, sample_d;
  logic [jci_pkg::MS_W-1:0]          now_q, now_d;

  logic        m_tvalid_q, m_tvalid_d;
  logic [23:0] m_tdata_q, m_tdata_d;

  logic                              s_acc, outside;
  logic [jci_pkg::RATE_W-1:0]        sample_u, smag, rsel_u, rmag, rquot;
  logic signed [jci_pkg::RATE_W-1:0] rsel;
  logic [jci_pkg::SIZE_W-1:0]        size_sel, load_lim;
  logic [jci_pkg::START_W-1:0]       load_start;
  logic [PW-1:0]                     lim, pos_sel, load_pos;
  logic [SW-1:0]                     sum, q_ext, lim_ext;
  logic [jci_pkg::CNT16_W-1:0]       fcnt_inc;
  logic [jci_pkg::MS_W-1:0]          elapsed;

  assign ucode       = jci_pkg::prog_rom(pc_q);
  assign s_tready_o  = (ucode.op == jci_pkg::OP_WAIT_IN);
  assign s_acc       = s_tvalid_i && s_tready_o;
  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o  = m_tvalid_q;
  assign m_tdata_o   = m_tdata_q;

  always_comb begin
    sample_u = sample_q;
    smag     = sample_q[jci_pkg::RATE_W-1] ? (~sample_u + 16'd1) : sample_u;
    outside  = (sample_q < jci_pkg::DEAD_LOW) || (sample_q > jci_pkg::DEAD_HIGH);
    rquot    = div_rsp.quot[jci_pkg::RATE_W-1:0];

    rsel     = rate_q[ucode.axis];
    rsel_u   = rsel;
    rmag     = rsel[jci_pkg::RATE_W-1] ? (~rsel_u + 16'd1) : rsel_u;

    size_sel = ucode.axis ? height_q : width_q;
    lim      = {size_sel, {F{1'b0}}};
    pos_sel  = pos_q[ucode.axis];
    q_ext    = {2'b00, div_rsp.quot};
    lim_ext  = SW'(lim);
    sum      = rsel[jci_pkg::RATE_W-1] ? (SW'(pos_sel) - q_ext) : (SW'(pos_sel) + q_ext);

    fcnt_inc = (fcnt_q != 16'hFFFF) ? (fcnt_q + 16'd1) : fcnt_q;
    elapsed  = now_q - last_q;

    load_start = (cfg_index_i == jci_pkg::REG_START_Y) ? cfg_data_i : cfg_data_i;
    load_lim   = (cfg_index_i == jci_pkg::REG_START_Y) ? height_q : width_q;
    load_pos   = (load_start < jci_pkg::START_W'(load_lim)) ?
                 {load_start[jci_pkg::SIZE_W-1:0], {F{1'b0}}} : {load_lim, {F{1'b0}}};
  end

  always_comb begin
    pc_d       = pc_q;
    width_d    = width_q;
    height_d   = height_q;
    divider_d  = divider_q;
    start_x_d  = start_x_q;
    start_y_d  = start_y_q;
    rate_d     = rate_q;
    pos_d      = pos_q;
    fcnt_d     = fcnt_q;
    fps_d      = fps_q;
    last_d     = last_q;
    motion_d   = motion_q;
    axis_d     = axis_q;
    sample_d   = sample_q;
    now_d      = now_q;
    m_tvalid_d = m_tvalid_q && !m_tready_i;
    m_tdata_d  = m_tdata_q;
    div_req    = '0;

    case (ucode.op)
      jci_pkg::OP_WAIT_IN: begin
        if (s_acc) begin
          motion_d = s_tuser_i[0];
          axis_d   = s_tuser_i[1];
          sample_d = s_tdata_i[15:0];
          now_d    = s_tdata_i[47:16];
          pc_d     = pc_q + 1'b1;
        end
      end
      jci_pkg::OP_DIV_RATE: begin
        if (motion_q && outside) begin
          div_req.start = 1'b1;
          div_req.numer = {smag, {F{1'b0}}};
          div_req.denom = {1'b0, (divider_q == '0) ? 16'd1 : divider_q};
          div_req.iters = jci_pkg::CNT_W'(jci_pkg::RATE_W);
          pc_d          = pc_q + 1'b1;
        end else begin
          pc_d = ucode.jmp;
        end
      end
      jci_pkg::OP_DIV_WAIT: begin
        if (!div_rsp.busy) begin
          pc_d = pc_q + 1'b1;
        end
      end
      jci_pkg::OP_RATE_WR: begin
        if (motion_q) begin
          if (outside) begin
            rate_d[axis_q] = sample_q[jci_pkg::RATE_W-1] ? (~rquot + 16'd1) : rquot;
          end else begin
            rate_d[axis_q] = '0;
          end
        end
        pc_d = pc_q + 1'b1;
      end
      jci_pkg::OP_DIV_STEP: begin
        div_req.start = 1'b1;
        div_req.numer = {rmag, {F{1'b0}}};
        div_req.denom = {1'b0, fps_q} + 17'd1;
        div_req.iters = jci_pkg::CNT_W'(jci_pkg::DIV_N);
        pc_d          = pc_q + 1'b1;
      end
      jci_pkg::OP_POS_UPD: begin
        if (sum[SW-1]) begin
          pos_d[ucode.axis] = '0;
        end else if (sum > lim_ext) begin
          pos_d[ucode.axis] = lim;
        end else begin
          pos_d[ucode.axis] = sum[PW-1:0];
        end
        pc_d = pc_q + 1'b1;
      end
      jci_pkg::OP_FRAME: begin
        if (elapsed > jci_pkg::LATCH_MS) begin
          last_d = now_q;
          fps_d  = fcnt_inc;
          fcnt_d = '0;
        end else begin
          fcnt_d = fcnt_inc;
        end
        pc_d = pc_q + 1'b1;
      end
      jci_pkg::OP_OUT: begin
        if (!m_tvalid_q || m_tready_i) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {pos_q[1][PW-1:F], pos_q[0][PW-1:F]};
          pc_d       = ucode.jmp;
        end
      end
      default: begin
        pc_d = jci_pkg::PC_WAIT_IN;
      end
    endcase

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        jci_pkg::REG_WIDTH:   width_d   = cfg_data_i[jci_pkg::SIZE_W-1:0];
        jci_pkg::REG_HEIGHT:  height_d  = cfg_data_i[jci_pkg::SIZE_W-1:0];
        jci_pkg::REG_DIVIDER: divider_d = cfg_data_i;
        jci_pkg::REG_START_X: begin
          start_x_d = cfg_data_i;
          pos_d[0]  = load_pos;
        end
        jci_pkg::REG_START_Y: begin
          start_y_d = cfg_data_i;
          pos_d[1]  = load_pos;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= jci_pkg::PC_WAIT_IN;
      width_q    <= 12'd480;
      height_q   <= 12'd272;
      divider_q  <= 16'd1;
      start_x_q  <= '0;
      start_y_q  <= '0;
      rate_q[0]  <= '0;
      rate_q[1]  <= '0;
      pos_q[0]   <= '0;
      pos_q[1]   <= '0;
      fcnt_q     <= '0;
      fps_q      <= '0;
      last_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      pc_q       <= pc_d;
      width_q    <= width_d;
      height_q   <= height_d;
      divider_q  <= divider_d;
      start_x_q  <= start_x_d;
      start_y_q  <= start_y_d;
      rate_q     <= rate_d;
      pos_q      <= pos_d;
      fcnt_q     <= fcnt_d;
      fps_q      <= fps_d;
      last_q     <= last_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    motion_q  <= motion_d;
    axis_q    <= axis_d;
    sample_q  <= sample_d;
    now_q     <= now_d;
    m_tdata_q <= m_tdata_d;
  end

  jci_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) s_tready_o |-> !div_rsp.busy)
    else $error("divider busy while waiting for a new word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ucode.op == jci_pkg::OP_POS_UPD) |-> !div_rsp.busy)
    else $error("cursor updated before the step quotient was ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> pc_q == jci_pkg::PC_RATE)
    else $error("sequencer did not start the program after accepting a word");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pc_q <= jci_pkg::PC_LAST)
    else $error("sequencer left the program");

endmodule

// ===== hw/rtl/jci_div.sv =====
module jci_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jci_pkg::div_req_t  req_i,
  output jci_pkg::div_rsp_t  rsp_o
);

  logic [jci_pkg::DIV_N-1:0] num_q, num_d;
  logic [jci_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [jci_pkg::DEN_W-1:0] den_q, den_d;
  logic [jci_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [jci_pkg::DEN_W:0]   rem_sh;
  logic [jci_pkg::DEN_W:0]   diff;

  always_comb begin
    rem_sh = {rem_q, num_q[jci_pkg::DIV_N-1]};
    diff   = rem_sh - {1'b0, den_q};
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      num_d = req_i.numer;
      rem_d = '0;
      den_d = req_i.denom;
      cnt_d = req_i.iters;
    end else if (cnt_q != '0) begin
      if (!diff[jci_pkg::DEN_W]) begin
        rem_d = diff[jci_pkg::DEN_W-1:0];
        num_d = {num_q[jci_pkg::DIV_N-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[jci_pkg::DEN_W-1:0];
        num_d = {num_q[jci_pkg::DIV_N-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.quot = num_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned PHASE_EVENTS = 250;
  localparam int unsigned NUM_PHASES   = 7;
  localparam longint      ONE_FIX      = longint'(1) << jci_pkg::FRAC_BITS;

  localparam logic [jci_pkg::CFG_IX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [jci_pkg::CFG_IX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic ACT_OTHER  = 1'b0;
  localparam logic ACT_MOTION = 1'b1;
  localparam logic AXIS_X     = 1'b0;
  localparam logic AXIS_Y     = 1'b1;

  typedef struct packed {
    logic                     action;
    logic                     axis;
    logic [15:0]              sample;
    logic [jci_pkg::MS_W-1:0] now;
  } joy_event_t;

  typedef struct packed {
    logic [jci_pkg::SIZE_W-1:0] x;
    logic [jci_pkg::SIZE_W-1:0] y;
  } cursor_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  joy_event_t                   s_event = '0;
  logic [47:0]                  s_tdata;
  logic [1:0]                   s_tuser;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [23:0]                  m_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [jci_pkg::CFG_IX_W-1:0] cfg_index = '0;
  logic [jci_pkg::CFG_W-1:0]    cfg_data = '0;

  assign s_tdata = {s_event.now, s_event.sample};
  assign s_tuser = {s_event.axis, s_event.action};

  joystick_cursor_integrator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  logic [jci_pkg::SIZE_W-1:0] width_q, height_q;
  logic [15:0]                divider_q, start_x_q, start_y_q;
  int                         rate_q [2];
  longint                     pos_q [2];
  int unsigned                frames_q, fps_q;
  logic [jci_pkg::MS_W-1:0]   latch_ms_q;
  logic [jci_pkg::MS_W-1:0]   ms_now;

  joy_event_t  pending_q [$];
  cursor_t     cursor_q [$];
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 69;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned queued_n = 0;
  int unsigned checked_n = 0;
  cursor_t     want_c;

  function automatic void load_cursor(input int ax);
    longint lim, s;
    lim = ax ? height_q : width_q;
    s = ax ? start_y_q : start_x_q;
    pos_q[ax] = (s < lim ? s : lim) * ONE_FIX;
  endfunction

  function automatic void reset_cursor_model();
    width_q = 12'd480;
    height_q = 12'd272;
    divider_q = 16'd1;
    start_x_q = '0;
    start_y_q = '0;
    rate_q[0] = 0;
    rate_q[1] = 0;
    frames_q = 0;
    fps_q = 0;
    latch_ms_q = '0;
    load_cursor(0);
    load_cursor(1);
  endfunction

  function automatic void apply_reg(input logic [jci_pkg::CFG_IX_W-1:0] idx,
                                    input logic [jci_pkg::CFG_W-1:0] data);
    case (idx)
      jci_pkg::REG_WIDTH: begin
        width_q = data[jci_pkg::SIZE_W-1:0];
      end
      jci_pkg::REG_HEIGHT: begin
        height_q = data[jci_pkg::SIZE_W-1:0];
      end
      jci_pkg::REG_DIVIDER: begin
        divider_q = data;
      end
      jci_pkg::REG_START_X: begin
        start_x_q = data;
        load_cursor(0);
      end
      jci_pkg::REG_START_Y: begin
        start_y_q = data;
        load_cursor(1);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic cursor_t advance_cursor(input joy_event_t ev);
    int      smp, div;
    longint  stride, lim, p;
    cursor_t res;
    smp = $signed(ev.sample);
    if (ev.action == ACT_MOTION) begin
      if (smp < int'(jci_pkg::DEAD_LOW) || smp > int'(jci_pkg::DEAD_HIGH)) begin
        div = (divider_q == 0) ? 1 : int'(divider_q);
        rate_q[ev.axis] = smp / div;
      end else begin
        rate_q[ev.axis] = 0;
      end
    end
    for (int ax = 0; ax < 2; ax++) begin
      stride = (longint'(rate_q[ax]) * ONE_FIX) / (longint'(fps_q) + 1);
      lim = longint'(ax ? height_q : width_q) * ONE_FIX;
      p = pos_q[ax] + stride;
      if (p < 0) begin
        p = 0;
      end else if (p > lim) begin
        p = lim;
      end
      pos_q[ax] = p;
    end
    if (frames_q < 65535) begin
      frames_q++;
    end
    if ((ev.now - latch_ms_q) > jci_pkg::LATCH_MS) begin
      latch_ms_q = ev.now;
      fps_q = frames_q;
      frames_q = 0;
    end
    res.x = jci_pkg::SIZE_W'(pos_q[0] / ONE_FIX);
    res.y = jci_pkg::SIZE_W'(pos_q[1] / ONE_FIX);
    return res;
  endfunction

  function automatic void push_event(input logic action, input logic axis,
                                     input logic [15:0] sample,
                                     input logic [jci_pkg::MS_W-1:0] now);
    joy_event_t ev;
    ev.action = action;
    ev.axis = axis;
    ev.sample = sample;
    ev.now = now;
    pending_q.push_back(ev);
    queued_n++;
    ms_now = now;
  endfunction

  function automatic joy_event_t random_event();
    joy_event_t ev;
    int unsigned pick;
    ev.action = ($urandom_range(0, 99) < 75) ? ACT_MOTION : ACT_OTHER;
    ev.axis = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: ev.sample = 16'($urandom_range(0, 4000) - 2000);
      1: begin
        case ($urandom_range(0, 3))
          0: ev.sample = jci_pkg::DEAD_HIGH;
          1: ev.sample = jci_pkg::DEAD_HIGH + 16'sd1;
          2: ev.sample = jci_pkg::DEAD_LOW;
          default: ev.sample = jci_pkg::DEAD_LOW - 16'sd1;
        endcase
      end
      2: ev.sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: ev.sample = 16'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 90) begin
      ms_now = ms_now + $urandom_range(0, 25);
    end else if (pick < 95) begin
      ms_now = ms_now + jci_pkg::LATCH_MS + $urandom_range(0, 1);
    end else if (pick < 98) begin
      ms_now = $urandom;
    end else begin
      ms_now = ms_now + $urandom_range(1002, 3000);
    end
    ev.now = ms_now;
    return ev;
  endfunction

  task automatic wr_reg(input logic [jci_pkg::CFG_IX_W-1:0] idx,
                        input logic [jci_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic wait_drained();
    while (checked_n < queued_n) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_phase_regs(input int unsigned phase);
    case (phase)
      0: begin
        wr_reg(jci_pkg::REG_WIDTH, 16'd4095);
        wr_reg(jci_pkg::REG_HEIGHT, 16'd4095);
        wr_reg(jci_pkg::REG_DIVIDER, 16'd1);
        wr_reg(jci_pkg::REG_START_X, 16'hFFFF);
        wr_reg(jci_pkg::REG_START_Y, 16'd0);
      end
      1: begin
        wr_reg(jci_pkg::REG_START_X, 16'd0);
        wr_reg(jci_pkg::REG_START_Y, 16'hFFFF);
        wr_reg(jci_pkg::REG_WIDTH, 16'd0);
        wr_reg(jci_pkg::REG_HEIGHT, 16'd0);
        wr_reg(jci_pkg::REG_DIVIDER, 16'hFFFF);
      end
      2: begin
        wr_reg(jci_pkg::REG_WIDTH, 16'($urandom));
        wr_reg(jci_pkg::REG_HEIGHT, 16'($urandom));
        wr_reg(jci_pkg::REG_DIVIDER, 16'd0);
        wr_reg(jci_pkg::REG_START_X, 16'($urandom));
        wr_reg(jci_pkg::REG_START_Y, 16'($urandom_range(0, 4095)));
        wr_reg(jci_pkg::CFG_IX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
      end
      3: begin
        wr_reg(jci_pkg::REG_WIDTH, 16'($urandom_range(0, 600)));
        wr_reg(jci_pkg::REG_HEIGHT, 16'($urandom_range(0, 600)));
        wr_reg(jci_pkg::REG_DIVIDER, 16'($urandom_range(50, 800)));
      end
      4: begin
        wr_reg(jci_pkg::REG_WIDTH, 16'd480);
        wr_reg(jci_pkg::REG_HEIGHT, 16'd272);
        wr_reg(jci_pkg::REG_DIVIDER, 16'd200);
        wr_reg(jci_pkg::REG_START_X, 16'd240);
        wr_reg(jci_pkg::REG_START_Y, 16'd136);
      end
      5: begin
        wr_reg(jci_pkg::REG_WIDTH, 16'($urandom_range(1, 4095)));
        wr_reg(jci_pkg::REG_HEIGHT, 16'($urandom_range(1, 4095)));
        wr_reg(jci_pkg::REG_DIVIDER, 16'($urandom_range(50, 800)));
        wr_reg(jci_pkg::REG_START_X, 16'($urandom_range(0, 4095)));
        wr_reg(jci_pkg::REG_START_Y, 16'($urandom_range(0, 4095)));
      end
      default: begin
        wr_reg(jci_pkg::REG_WIDTH, 16'd4095);
        wr_reg(jci_pkg::REG_HEIGHT, 16'd4095);
        wr_reg(jci_pkg::REG_DIVIDER, 16'd100);
        wr_reg(jci_pkg::REG_START_X, 16'd2048);
        wr_reg(jci_pkg::CFG_IX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
        wr_reg(jci_pkg::REG_START_Y, 16'd2048);
      end
    endcase
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    reset_cursor_model();
    ms_now = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The opening events walk the dead-zone edges, the sample extremes and the latch
    // boundary, including the wrap of the millisecond count.
    push_event(ACT_OTHER, AXIS_Y, 16'hFFFF, 32'd0);
    push_event(ACT_MOTION, AXIS_X, jci_pkg::DEAD_HIGH, 32'd5);
    push_event(ACT_MOTION, AXIS_X, jci_pkg::DEAD_HIGH + 16'sd1, 32'd10);
    push_event(ACT_MOTION, AXIS_Y, jci_pkg::DEAD_LOW - 16'sd1, 32'd20);
    push_event(ACT_MOTION, AXIS_Y, jci_pkg::DEAD_HIGH + 16'sd1, 32'd30);
    push_event(ACT_MOTION, AXIS_Y, jci_pkg::DEAD_LOW, 32'd40);
    push_event(ACT_MOTION, AXIS_X, 16'h8000, 32'd50);
    push_event(ACT_MOTION, AXIS_X, jci_pkg::DEAD_LOW, 32'd60);
    push_event(ACT_MOTION, AXIS_X, 16'h7FFF, 32'd70);
    push_event(ACT_OTHER, AXIS_X, 16'h0000, 32'd1000);
    push_event(ACT_OTHER, AXIS_X, 16'h1234, 32'd1001);
    push_event(ACT_MOTION, AXIS_Y, jci_pkg::DEAD_LOW - 16'sd1, 32'd1002);
    push_event(ACT_MOTION, AXIS_X, 16'hF448, 32'd1010);
    push_event(ACT_OTHER, AXIS_Y, 16'h7FFF, 32'd2001);
    push_event(ACT_OTHER, AXIS_Y, 16'h8000, 32'd2002);
    push_event(ACT_OTHER, AXIS_X, 16'h5555, 32'hFFFF_FF00);
    push_event(ACT_MOTION, AXIS_X, 16'h7FFF, 32'hFFFF_FFF0);
    push_event(ACT_OTHER, AXIS_Y, 16'hAAAA, 32'h0000_02E8);
    push_event(ACT_OTHER, AXIS_X, 16'h0001, 32'h0000_02E9);
    push_event(ACT_MOTION, AXIS_Y, 16'h0001, 32'h0000_02F0);
    push_event(ACT_OTHER, AXIS_X, 16'h8000, 32'h0000_0300);
    wait_drained();

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 7;
        recv_idle_pct = 69;
      end else if (phase < 4) begin
        send_idle_pct = 69;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_phase_regs(phase);
      repeat (PHASE_EVENTS) begin
        pending_q.push_back(random_event());
        queued_n++;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        cursor_q.push_back(advance_cursor(s_event));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_event <= pending_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      checked_n++;
      if (cursor_q.size() == 0) begin
        mismatches++;
        $display("%0t: word with nothing expected, expected none, actual %h", $time, m_tdata);
      end else begin
        want_c = cursor_q.pop_front();
        if (m_tdata[jci_pkg::SIZE_W-1:0] !== want_c.x) begin
          mismatches++;
          $display("%0t: pointer_x expected %0d, actual %0d", $time, want_c.x,
                   m_tdata[jci_pkg::SIZE_W-1:0]);
        end
        if (m_tdata[2*jci_pkg::SIZE_W-1:jci_pkg::SIZE_W] !== want_c.y) begin
          mismatches++;
          $display("%0t: pointer_y expected %0d, actual %0d", $time, want_c.y,
                   m_tdata[2*jci_pkg::SIZE_W-1:jci_pkg::SIZE_W]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/jci_pkg.sv
hw/rtl/jci_div.sv
hw/rtl/joystick_cursor_integrator.sv
verif/tb_top.sv
